[rtl/bss_pkg.sv]
// ----------------------------------------------------------------------------
// Boot strap sequencer package
// Shared mode codes, register map constants and the result record used by
// the sequencer core and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

   // Mode codes, used both for the wanted mode and for the mode reached.
   typedef enum logic [1:0] {
      ModeUnknown  = 2'd0,
      ModeDisabled = 2'd1,
      ModeBoot     = 2'd2,
      ModeApp      = 2'd3
   } mode_type;

   // Register map.
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;
   localparam int unsigned SettleWidth  = 8;
   localparam logic [SettleWidth-1:0] SettleReset = 8'd5;

   // Register index taken from the word address bit.
   typedef enum logic {
      RegSettleTicks = 1'b0,
      RegUnused      = 1'b1
   } reg_index_type;

   // One result of a tick.
   typedef struct packed {
      logic     reset_pin;
      logic     enable_pin;
      logic     flash_pin;
      mode_type reached_mode;
   } result_type;

endpackage

`default_nettype wire

[rtl/bss_req_if.sv]
// ----------------------------------------------------------------------------
// Boot strap sequencer request channel
// Valid/ready channel that carries the wanted mode of one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] requested_mode;

   modport source (output valid, output requested_mode, input ready);
   modport sink (input valid, input requested_mode, output ready);
endinterface

`default_nettype wire

[rtl/bss_rsp_if.sv]
// ----------------------------------------------------------------------------
// Boot strap sequencer result channel
// Valid/ready channel that carries the pin levels and reached mode of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface bss_rsp_if;
   logic       valid;
   logic       ready;
   logic       reset_pin;
   logic       enable_pin;
   logic       flash_pin;
   logic [1:0] reached_mode;

   modport source (output valid, output reset_pin, output enable_pin,
                   output flash_pin, output reached_mode, input ready);
   modport sink (input valid, input reset_pin, input enable_pin,
                 input flash_pin, input reached_mode, output ready);
endinterface

`default_nettype wire

[rtl/bss_core.sv]
// ----------------------------------------------------------------------------
// Boot strap sequencer core
// Holds the phase, settle timer and pin levels, and works out one tick of
// the sequence whenever step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 step,
   input  wire [1:0]                           requested_mode,
   input  wire [bss_pkg::SettleWidth-1:0]      settle_ticks,
   output bss_pkg::result_type                 result
);

   // One-hot phase encoding.
   typedef enum logic [7:0] {
      PhInit       = 8'b0000_0001,
      PhAwaitReset = 8'b0000_0010,
      PhReset      = 8'b0000_0100,
      PhAwaitFlash = 8'b0000_1000,
      PhAwaitEn    = 8'b0001_0000,
      PhBoot       = 8'b0010_0000,
      PhAwaitApp   = 8'b0100_0000,
      PhApp        = 8'b1000_0000
   } phase_type;

   phase_type                       phase_ff, phase_in;
   logic [bss_pkg::SettleWidth-1:0] timer_ff, timer_in;
   logic                            reset_level_ff, reset_level_in;
   logic                            enable_level_ff, enable_level_in;
   logic                            flash_level_ff, flash_level_in;
   logic [bss_pkg::SettleWidth-1:0] timer_dec;
   logic                            go_on;
   logic                            want_boot;
   logic                            want_app;
   logic                            want_disabled;

   assign timer_dec     = (timer_ff != '0) ?
                          timer_ff - {{(bss_pkg::SettleWidth-1){1'b0}}, 1'b1} : timer_ff;
   assign want_boot     = (requested_mode == bss_pkg::ModeBoot);
   assign want_app      = (requested_mode == bss_pkg::ModeApp);
   assign want_disabled = (requested_mode == bss_pkg::ModeDisabled);

   // Next state of one tick; a wait phase whose timer has run out falls
   // through into the following phase within the same tick.
   always_comb begin
      phase_in        = phase_ff;
      timer_in        = timer_dec;
      reset_level_in  = reset_level_ff;
      enable_level_in = enable_level_ff;
      flash_level_in  = flash_level_ff;
      go_on           = 1'b1;
      unique case (phase_ff) inside
         PhInit: begin
            timer_in        = settle_ticks;
            reset_level_in  = 1'b1;
            enable_level_in = 1'b0;
            flash_level_in  = 1'b0;
            phase_in        = PhAwaitReset;
         end
         PhAwaitReset, PhReset: begin
            if (phase_ff == PhReset || timer_dec == '0) begin
               phase_in = PhReset;
               if (want_boot) begin
                  timer_in       = settle_ticks;
                  flash_level_in = 1'b1;
                  phase_in       = PhAwaitFlash;
               end else if (want_app) begin
                  timer_in        = settle_ticks;
                  enable_level_in = 1'b1;
                  phase_in        = PhAwaitApp;
               end
            end
         end
         PhAwaitFlash, PhAwaitEn, PhBoot: begin
            // Flash strap settled: release reset with enable high.
            if (phase_ff == PhAwaitFlash) begin
               if (timer_dec != '0) begin
                  go_on = 1'b0;
               end else begin
                  timer_in        = settle_ticks;
                  enable_level_in = 1'b1;
                  reset_level_in  = 1'b0;
                  phase_in        = PhAwaitEn;
               end
            end
            // Enable settled: boot mode reached.
            if (go_on && phase_in == PhAwaitEn) begin
               if (timer_in != '0) begin
                  go_on = 1'b0;
               end else begin
                  phase_in = PhBoot;
               end
            end
            if (go_on && (want_disabled || want_app)) begin
               timer_in        = settle_ticks;
               enable_level_in = 1'b0;
               reset_level_in  = 1'b1;
               flash_level_in  = 1'b0;
               phase_in        = PhAwaitReset;
            end
         end
         PhAwaitApp, PhApp: begin
            if (phase_ff == PhApp || timer_dec == '0) begin
               phase_in = PhApp;
               if (want_disabled || want_boot) begin
                  timer_in        = settle_ticks;
                  enable_level_in = 1'b0;
                  reset_level_in  = 1'b1;
                  flash_level_in  = 1'b0;
                  phase_in        = PhAwaitReset;
               end
            end
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   // Reported mode follows the phase after this tick.
   always_comb begin
      result.reset_pin  = reset_level_in;
      result.enable_pin = enable_level_in;
      result.flash_pin  = flash_level_in;
      unique case (phase_in)
         PhReset: result.reached_mode = bss_pkg::ModeDisabled;
         PhBoot:  result.reached_mode = bss_pkg::ModeBoot;
         PhApp:   result.reached_mode = bss_pkg::ModeApp;
         default: result.reached_mode = bss_pkg::ModeUnknown;
      endcase
   end

   // State registers advance once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PhInit;
         timer_ff        <= '0;
         reset_level_ff  <= 1'b1;
         enable_level_ff <= 1'b0;
         flash_level_ff  <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         timer_ff        <= timer_in;
         reset_level_ff  <= reset_level_in;
         enable_level_ff <= enable_level_in;
         flash_level_ff  <= flash_level_in;
      end
   end

endmodule

`default_nettype wire

[rtl/module_boot_strap_sequencer.sv]
// ----------------------------------------------------------------------------
// Module boot strap sequencer
// Steps a wireless module's reset, enable and flash strap pins toward the
// wanted mode, one request per tick, and reports pin levels and mode reached.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  req_chan  in         requested_mode, one request per tick
//  rsp_chan  out        reset_pin, enable_pin, flash_pin, reached_mode
//  csr_*     in/out     settle_ticks register at byte address 0
//
//  A request is registered in the input register on acceptance and its result
//  in the output register; one request is taken per cycle unless rsp stalls.
//  The sequencer core is the only stage that holds tick state.
//  A stalled result holds in the output register; the input register then takes
//  one more request and holds it until the core can step.
//  Synchronous active-high reset clears both stages and the sequencer state.
// ----------------------------------------------------------------------------
`default_nettype none

module module_boot_strap_sequencer (
   input  wire                                 clock,
   input  wire                                 reset,
   bss_req_if.sink                             req_chan,
   bss_rsp_if.source                           rsp_chan,
   input  wire                                 csr_psel,
   input  wire                                 csr_penable,
   input  wire                                 csr_pwrite,
   input  wire [bss_pkg::CsrAddrWidth-1:0]     csr_paddr,
   input  wire [bss_pkg::CsrDataWidth-1:0]     csr_pwdata,
   output logic [bss_pkg::CsrDataWidth-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic                            in_valid_ff;
   logic [1:0]                      in_mode_ff;
   logic                            out_valid_ff;
   bss_pkg::result_type             out_data_ff;
   bss_pkg::result_type             core_result;
   logic [bss_pkg::SettleWidth-1:0] settle_ff;
   logic                            advance;
   logic                            csr_write;
   bss_pkg::reg_index_type          csr_index;

   // Configuration register access.
   assign csr_pready = 1'b1;
   assign csr_index  = bss_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_index)
         bss_pkg::RegSettleTicks:
            csr_prdata = {{(bss_pkg::CsrDataWidth-bss_pkg::SettleWidth){1'b0}}, settle_ff};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= bss_pkg::SettleReset;
      end else if (csr_write && csr_index == bss_pkg::RegSettleTicks) begin
         settle_ff <= csr_pwdata[bss_pkg::SettleWidth-1:0];
      end
   end

   // The core steps when a request is held and the output register is free or being read.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_mode_ff <= req_chan.requested_mode;
      end
   end

   bss_core u_core (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .requested_mode (in_mode_ff),
      .settle_ticks   (settle_ff),
      .result         (core_result)
   );

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.reset_pin    = out_data_ff.reset_pin;
   assign rsp_chan.enable_pin   = out_data_ff.enable_pin;
   assign rsp_chan.flash_pin    = out_data_ff.flash_pin;
   assign rsp_chan.reached_mode = out_data_ff.reached_mode;

   // Disabled mode is only reported with the module held in reset.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.reached_mode == bss_pkg::ModeDisabled
      |-> out_data_ff.reset_pin && !out_data_ff.enable_pin && !out_data_ff.flash_pin)
      else $error("disabled mode reported with wrong pin levels");

   // Boot mode is only reported with reset released and the strap set.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.reached_mode == bss_pkg::ModeBoot
      |-> !out_data_ff.reset_pin && out_data_ff.enable_pin && out_data_ff.flash_pin)
      else $error("boot mode reported with wrong pin levels");

   // Application mode is only reported with enable high and no strap.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.reached_mode == bss_pkg::ModeApp
      |-> out_data_ff.reset_pin && out_data_ff.enable_pin && !out_data_ff.flash_pin)
      else $error("application mode reported with wrong pin levels");

   // A held request that cannot step stays held.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_mode_ff))
      else $error("stalled request lost");

endmodule

`default_nettype wire

[bench/module_boot_strap_sequencer_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Boot strap sequencer testbench
// Drives wanted-mode requests into the sequencer and checks every result
// against a cycle-free model of the pin sequencing. A short table of
// requests is run first. Random mode runs follow, under several settle
// settings and with random idling and stalls on both channels.
// ----------------------------------------------------------------------------

module module_boot_strap_sequencer_tb;

   // Sequencer steps as the model tracks them.
   typedef enum logic [2:0] {
      StepInit, StepAwaitReset, StepReset, StepAwaitFlash,
      StepAwaitEnable, StepBoot, StepAwaitApp, StepApp
   } seq_step_type;

   typedef enum logic [1:0] {
      IdleNone, IdleSender, IdleReceiver, IdleBoth
   } idle_type;

   // One row of the directed table. When load is set, settle_ticks is
   // written before the request; pins is used only when typed is set.
   typedef struct packed {
      logic                load;
      logic [7:0]          settle;
      bss_pkg::mode_type   want;
      logic                typed;
      bss_pkg::result_type pins;
   } directed_row_type;

   // One random phase: settle setting (or a random pick), idling, length and squeeze.
   typedef struct packed {
      logic [7:0]  settle;
      logic        pick;
      idle_type    idling;
      logic [10:0] count;
      logic        squeeze;
   } random_phase_type;

   localparam int HoldOffCycles = 60;
   localparam int DrainCycles   = 6;

   localparam directed_row_type DirectedRows [25] = '{
      '{1'b1, 8'd1, bss_pkg::ModeApp, 1'b1, '{1'b1, 1'b0, 1'b0, bss_pkg::ModeUnknown}},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeDisabled, 1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeDisabled, 1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeDisabled, 1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeDisabled, 1'b0, '0},
      '{1'b1, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeDisabled, 1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeBoot,     1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeApp,      1'b0, '0},
      '{1'b0, 8'd0, bss_pkg::ModeUnknown,  1'b0, '0}
   };

   localparam random_phase_type RandomPhases [5] = '{
      '{8'd5,   1'b0, IdleNone,     11'd150, 1'b0},
      '{8'd2,   1'b0, IdleSender,   11'd150, 1'b0},
      '{8'd0,   1'b0, IdleReceiver, 11'd120, 1'b0},
      '{8'd0,   1'b1, IdleBoth,     11'd150, 1'b1},
      '{8'd255, 1'b0, IdleBoth,     11'd520, 1'b0}
   };

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [bss_pkg::CsrAddrWidth-1:0] csr_paddr = '0;
   logic [bss_pkg::CsrDataWidth-1:0] csr_pwdata = '0;
   logic [bss_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                             csr_pready;

   bss_req_if req_chan();
   bss_rsp_if rsp_chan();

   module_boot_strap_sequencer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Model state, starting from its reset values.
   seq_step_type model_step   = StepInit;
   logic [7:0]   settle_ticks = bss_pkg::SettleReset;
   logic [7:0]   settle_left  = 8'd0;
   logic         reset_lvl    = 1'b1;
   logic         enable_lvl   = 1'b0;
   logic         flash_lvl    = 1'b0;

   bss_pkg::result_type expected_pins [$];
   int                  mismatch_count = 0;

   // Stimulus control shared between the processes.
   idle_type            idle_mode = IdleNone;
   logic                offer_typed = 1'b0;
   bss_pkg::result_type offer_pins = '0;
   int                  hold_off_asked = 0;
   int                  hold_off_served = 0;
   int                  hold_off_left = 0;
   bss_pkg::mode_type   run_mode = bss_pkg::ModeUnknown;
   int                  run_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Drive the module back to reset and start the settle wait.
   function automatic void restart_module();
      settle_left = settle_ticks;
      enable_lvl = 1'b0;
      reset_lvl = 1'b1;
      flash_lvl = 1'b0;
      model_step = StepAwaitReset;
   endfunction

   // From the reset step, a boot request raises flash, an application
   // request raises enable; anything else stays in reset.
   function automatic void leave_reset(bss_pkg::mode_type want);
      if (want == bss_pkg::ModeBoot) begin
         settle_left = settle_ticks;
         flash_lvl = 1'b1;
         model_step = StepAwaitFlash;
      end else if (want == bss_pkg::ModeApp) begin
         settle_left = settle_ticks;
         enable_lvl = 1'b1;
         model_step = StepAwaitApp;
      end
   endfunction

   // A settled mode is left for any known request other than itself.
   function automatic void hold_mode(bss_pkg::mode_type want, bss_pkg::mode_type held);
      if (want != bss_pkg::ModeUnknown && want != held) begin
         restart_module();
      end
   endfunction

   // One tick of the sequencer; expired waits fall through in the same tick.
   function automatic bss_pkg::result_type predict_pins(bss_pkg::mode_type want);
      bss_pkg::result_type pins;
      if (settle_left != 8'd0) begin
         settle_left = settle_left - 8'd1;
      end
      case (model_step)
         StepInit: begin
            restart_module();
         end
         StepAwaitReset: begin
            if (settle_left == 8'd0) begin
               model_step = StepReset;
               leave_reset(want);
            end
         end
         StepReset: begin
            leave_reset(want);
         end
         StepAwaitFlash: begin
            if (settle_left == 8'd0) begin
               settle_left = settle_ticks;
               enable_lvl = 1'b1;
               reset_lvl = 1'b0;
               model_step = StepAwaitEnable;
               if (settle_left == 8'd0) begin
                  model_step = StepBoot;
                  hold_mode(want, bss_pkg::ModeBoot);
               end
            end
         end
         StepAwaitEnable: begin
            if (settle_left == 8'd0) begin
               model_step = StepBoot;
               hold_mode(want, bss_pkg::ModeBoot);
            end
         end
         StepBoot: begin
            hold_mode(want, bss_pkg::ModeBoot);
         end
         StepAwaitApp: begin
            if (settle_left == 8'd0) begin
               model_step = StepApp;
               hold_mode(want, bss_pkg::ModeApp);
            end
         end
         default: begin
            hold_mode(want, bss_pkg::ModeApp);
         end
      endcase
      pins.reset_pin = reset_lvl;
      pins.enable_pin = enable_lvl;
      pins.flash_pin = flash_lvl;
      case (model_step)
         StepReset: pins.reached_mode = bss_pkg::ModeDisabled;
         StepBoot:  pins.reached_mode = bss_pkg::ModeBoot;
         StepApp:   pins.reached_mode = bss_pkg::ModeApp;
         default:   pins.reached_mode = bss_pkg::ModeUnknown;
      endcase
      return pins;
   endfunction

   function automatic void note_mismatch(string what, logic [31:0] expected_v,
                                         logic [31:0] actual_v);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t: mismatch on %s: expected %0h, got %0h",
                  $realtime, what, expected_v, actual_v);
      end
   endfunction

   function automatic bit chance(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // Random mode runs of random length, with stray single requests between.
   function automatic bss_pkg::mode_type next_random_want();
      if (run_left == 0) begin
         if (chance(12)) begin
            return bss_pkg::mode_type'(2'($urandom_range(3)));
         end
         run_mode = bss_pkg::mode_type'(2'($urandom_range(3)));
         run_left = $urandom_range(3 * settle_ticks + 8, 1);
      end
      run_left--;
      return run_mode;
   endfunction

   // Record the expectation of every accepted request.
   always @(posedge clock) begin : take_request
      bss_pkg::result_type pins;
      if (!reset && req_chan.valid && req_chan.ready) begin
         pins = predict_pins(bss_pkg::mode_type'(req_chan.requested_mode));
         if (offer_typed) begin
            pins = offer_pins;
         end
         expected_pins.push_back(pins);
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin : check_result
      bss_pkg::result_type want_pins;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_pins.size() == 0) begin
            note_mismatch("result with no request pending", 32'd0,
                          {27'd0, rsp_chan.reset_pin, rsp_chan.enable_pin,
                           rsp_chan.flash_pin, rsp_chan.reached_mode});
         end else begin
            want_pins = expected_pins.pop_front();
            if (rsp_chan.reset_pin !== want_pins.reset_pin) begin
               note_mismatch("reset_pin", 32'(want_pins.reset_pin),
                             32'(rsp_chan.reset_pin));
            end
            if (rsp_chan.enable_pin !== want_pins.enable_pin) begin
               note_mismatch("enable_pin", 32'(want_pins.enable_pin),
                             32'(rsp_chan.enable_pin));
            end
            if (rsp_chan.flash_pin !== want_pins.flash_pin) begin
               note_mismatch("flash_pin", 32'(want_pins.flash_pin),
                             32'(rsp_chan.flash_pin));
            end
            if (rsp_chan.reached_mode !== want_pins.reached_mode) begin
               note_mismatch("reached_mode", 32'(want_pins.reached_mode),
                             32'(rsp_chan.reached_mode));
            end
         end
      end
   end

   // Result side: random stalls, plus a long hold-off when one is asked for.
   always @(negedge clock) begin : drive_receiver
      if (hold_off_asked != hold_off_served) begin
         hold_off_served <= hold_off_asked;
         hold_off_left <= HoldOffCycles;
         rsp_chan.ready <= 1'b0;
      end else if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= !chance(idle_mode == IdleReceiver ? 53 :
                                   idle_mode == IdleBoth ? 16 : 0);
      end
   end

   // Offer one request and return at the falling edge after it is taken.
   task automatic offer_request(bss_pkg::mode_type want, logic typed,
                                bss_pkg::result_type pins);
      while (chance(idle_mode == IdleSender ? 53 : idle_mode == IdleBoth ? 16 : 0)) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.requested_mode <= want;
      offer_typed <= typed;
      offer_pins <= pins;
      @(posedge clock);
      while (!req_chan.ready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Stop offering and wait until every result is in and the block is quiet.
   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (expected_pins.size() != 0) begin
         @(posedge clock);
      end
      repeat (DrainCycles) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(bss_pkg::reg_index_type idx, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (idx == bss_pkg::RegSettleTicks) begin
         settle_ticks = data[7:0];
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Read settle_ticks back and compare it with the model's copy.
   task automatic csr_expect_settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {bss_pkg::RegSettleTicks, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) begin
         @(posedge clock);
      end
      if (csr_prdata !== {24'd0, settle_ticks}) begin
         note_mismatch("settle_ticks readback", {24'd0, settle_ticks}, csr_prdata);
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits are random; only the low byte lands in the register.
   task automatic load_settle(logic [7:0] settle);
      logic [31:0] word;
      word = $urandom();
      word[7:0] = settle;
      csr_write(bss_pkg::RegSettleTicks, word);
      csr_expect_settle();
   endtask

   initial begin : stimulus
      logic [7:0] settle;
      req_chan.valid = 1'b0;
      req_chan.requested_mode = 2'd0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset value, then a write to the unused index that must change nothing.
      csr_expect_settle();
      csr_write(bss_pkg::RegUnused, 32'hFFFF_FFFF);
      csr_expect_settle();

      // Directed table: every mode change, the settle-of-one and zero cases.
      for (int i = 0; i < 25; i++) begin
         if (DirectedRows[i].load) begin
            wait_idle();
            load_settle(DirectedRows[i].settle);
         end
         offer_request(DirectedRows[i].want, DirectedRows[i].typed,
                       DirectedRows[i].pins);
      end

      // Random mode runs under several settle settings and idling patterns.
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         settle = RandomPhases[p].settle;
         if (RandomPhases[p].pick) begin
            settle = 8'($urandom_range(12, 3));
         end
         load_settle(settle);
         idle_mode <= RandomPhases[p].idling;
         run_left = 0;
         for (int n = 0; n < RandomPhases[p].count; n++) begin
            // Hold the result side off while requests keep coming.
            if (RandomPhases[p].squeeze && n == 40) begin
               hold_off_asked <= hold_off_asked + 1;
            end
            offer_request(next_random_want(), 1'b0, '0);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #400000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
